### hw/rtl/rlfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared package of the RGB LED fade engine: widths, register and mode codes,
// and the layout of one LED row in the state memory. No dependencies.

package rlfe_pkg;

  localparam int unsigned LED_COUNT_DEF = 64;

  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned MORPH_W = 16;
  localparam int unsigned TICK_W  = 10;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  // Divider operand widths: dividends reach 2*i*M + D, divisors reach 2*D.
  localparam int unsigned NUM_W  = 25;
  localparam int unsigned DEN_W  = 19;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned DD_W   = 18;
  localparam int unsigned PROD_W = 24;

  localparam logic [MORPH_W-1:0] MORPH_RESET = 16'd1000;
  localparam logic [TICK_W-1:0]  TICK_RESET  = 10'd10;

  typedef enum logic {
    REG_MORPH = 1'b0,
    REG_TICK  = 1'b1
  } reg_idx_e;

  typedef enum logic {
    MODE_START = 1'b0,
    MODE_TICK  = 1'b1
  } mode_e;

  typedef struct packed {
    logic [LEVEL_W-1:0]        cur;
    logic [LEVEL_W-1:0]        tgt;
    logic signed [LEVEL_W-1:0] step;
    logic [LEVEL_W-1:0]        wcnt;
    logic [LEVEL_W-1:0]        wrld;
  } chan_t;

  typedef chan_t [2:0] row_t;

endpackage

`default_nettype wire

### hw/rtl/rgb_led_fade_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the RGB LED fade engine: command channel, APB registers and sequencer.
// Depends on rlfe_pkg and instantiates rlfe_mem and rlfe_plan.
//
// An item is transferred when start is high and busy is low. A start item (mode 0)
// loads current and target levels for one LED and plans a step and a wait per channel;
// a tick item (mode 1) counts down the waits of one LED and moves the levels.
// Each item yields one result, shown for one cycle with done_o high; the receiver
// cannot stall, so results are never held back.
// A tick item reads the LED row, updates it and writes it back: the read is registered,
// the result is registered in S_EXEC, and no new item is taken until the engine is idle.
// A start item runs the three channels through the shared 25-step restoring divider,
// up to three divisions per channel, one channel after another.
// An index at or beyond LED_COUNT gives a zero result in the cycle after the transfer.
// After reset the state memory is cleared, one LED row per cycle, through all LED_COUNT
// rows; busy stays high meanwhile. Registers may be written at any time while idle.

module rgb_led_fade_engine import rlfe_pkg::*; #(
  parameter int unsigned LED_COUNT = LED_COUNT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic               mode_i,
  input  logic [INDEX_W-1:0] led_index_i,
  input  logic [LEVEL_W-1:0] start_red_i,
  input  logic [LEVEL_W-1:0] start_green_i,
  input  logic [LEVEL_W-1:0] start_blue_i,
  input  logic [LEVEL_W-1:0] target_red_i,
  input  logic [LEVEL_W-1:0] target_green_i,
  input  logic [LEVEL_W-1:0] target_blue_i,
  output logic               done_o,
  output logic [INDEX_W-1:0] out_index_o,
  output logic [LEVEL_W-1:0] level_red_o,
  output logic [LEVEL_W-1:0] level_green_o,
  output logic [LEVEL_W-1:0] level_blue_o,
  output logic               active_o,
  output logic               changed_o
);

  localparam int unsigned AW        = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [1:0]  LAST_CHAN = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PSTART,
    S_PWAIT,
    S_WRITE
  } state_e;

  state_e                    state_q;
  mode_e                     mode_q;
  logic [INDEX_W-1:0]        idx_q;
  logic [2:0][LEVEL_W-1:0]   from_q;
  logic [2:0][LEVEL_W-1:0]   to_q;
  logic [1:0]                chan_q;
  row_t                      row_q;
  row_t                      old_q;
  logic [MORPH_W-1:0]        morph_q;
  logic [TICK_W-1:0]         tick_q;
  logic [TICK_W-1:0]         tick_eff;
  logic                      done_q;
  logic [INDEX_W-1:0]        out_index_q;
  logic [2:0][LEVEL_W-1:0]   level_q;
  logic                      active_q;
  logic                      changed_q;

  logic                      mem_ready;
  logic                      accept;
  logic                      in_range;
  logic [AW+INDEX_W-1:0]     rd_wide;
  logic [AW+INDEX_W-1:0]     wr_wide;
  row_t                      rd_data;
  row_t                      tick_row;
  row_t                      res_row;
  row_t                      ref_row;
  logic                      wr_en;
  logic                      res_active;
  logic                      res_changed;
  logic                      plan_done;
  logic signed [LEVEL_W-1:0] plan_step;
  logic [LEVEL_W-1:0]        plan_wait;

  function automatic chan_t tick_chan(chan_t c);
    chan_t             r;
    logic [LEVEL_W-1:0] w;
    logic signed [9:0]  sum;
    logic signed [9:0]  tgt;
    r   = c;
    w   = c.wcnt - 8'd1;
    sum = $signed({2'b00, c.cur}) + $signed({{2{c.step[7]}}, c.step});
    tgt = $signed({2'b00, c.tgt});
    if (c.cur != c.tgt && c.wcnt != '0) begin
      if (w != '0) begin
        r.wcnt = w;
      end else begin
        r.wcnt = c.wrld;
        if (c.step > 8'sd0 && c.cur < c.tgt) begin
          r.cur = (sum > tgt) ? c.tgt : sum[LEVEL_W-1:0];
        end else if (c.step < 8'sd0 && c.cur > c.tgt) begin
          r.cur = (sum < tgt) ? c.tgt : sum[LEVEL_W-1:0];
        end
      end
    end
    return r;
  endfunction

  assign pready   = 1'b1;
  assign busy     = (state_q != S_IDLE) || !mem_ready;
  assign accept   = start && !busy;
  assign in_range = 32'(led_index_i) < LED_COUNT;
  assign rd_wide  = {{AW{1'b0}}, led_index_i};
  assign wr_wide  = {{AW{1'b0}}, idx_q};
  assign tick_eff = (tick_q == '0) ? TICK_W'(1) : tick_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      morph_q <= MORPH_RESET;
      tick_q  <= TICK_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_e'(paddr[2]))
        REG_MORPH: morph_q <= pwdata[MORPH_W-1:0];
        REG_TICK:  tick_q  <= pwdata[TICK_W-1:0];
        default:   morph_q <= morph_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[2]))
      REG_MORPH: prdata = DATA_W'(morph_q);
      REG_TICK:  prdata = DATA_W'(tick_q);
      default:   prdata = '0;
    endcase
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      tick_row[c] = tick_chan(rd_data[c]);
    end
    res_row     = (state_q == S_WRITE) ? row_q : tick_row;
    ref_row     = (state_q == S_WRITE) ? old_q : rd_data;
    res_active  = 1'b0;
    res_changed = 1'b0;
    for (int c = 0; c < 3; c++) begin
      res_active  = res_active  | (res_row[c].cur != res_row[c].tgt);
      res_changed = res_changed | (res_row[c].cur != ref_row[c].cur);
    end
  end

  assign wr_en = (state_q == S_EXEC && mode_q == MODE_TICK) || (state_q == S_WRITE);

  rlfe_mem #(
    .DEPTH (LED_COUNT)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept && in_range),
    .rd_addr_i (rd_wide[AW-1:0]),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_wide[AW-1:0]),
    .wr_data_i (res_row),
    .ready_o   (mem_ready)
  );

  rlfe_plan u_plan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_PSTART),
    .from_i  (from_q[chan_q]),
    .to_i    (to_q[chan_q]),
    .morph_i (morph_q),
    .tick_i  (tick_eff),
    .done_o  (plan_done),
    .step_o  (plan_step),
    .wait_o  (plan_wait)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      chan_q  <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            mode_q <= mode_e'(mode_i);
            idx_q  <= led_index_i;
            from_q <= {start_blue_i, start_green_i, start_red_i};
            to_q   <= {target_blue_i, target_green_i, target_red_i};
            if (in_range) begin
              state_q <= S_EXEC;
            end else begin
              done_q      <= 1'b1;
              out_index_q <= led_index_i;
              level_q     <= '0;
              active_q    <= 1'b0;
              changed_q   <= 1'b0;
            end
          end
        end
        S_EXEC: begin
          if (mode_q == MODE_TICK) begin
            done_q      <= 1'b1;
            out_index_q <= idx_q;
            for (int c = 0; c < 3; c++) begin
              level_q[c] <= res_row[c].cur;
            end
            active_q  <= res_active;
            changed_q <= res_changed;
            state_q   <= S_IDLE;
          end else begin
            old_q   <= rd_data;
            chan_q  <= '0;
            state_q <= S_PSTART;
          end
        end
        S_PSTART: state_q <= S_PWAIT;
        S_PWAIT: begin
          if (plan_done) begin
            row_q[chan_q] <= '{cur:  from_q[chan_q],
                               tgt:  to_q[chan_q],
                               step: plan_step,
                               wcnt: plan_wait,
                               wrld: plan_wait};
            if (chan_q == LAST_CHAN) begin
              state_q <= S_WRITE;
            end else begin
              chan_q  <= chan_q + 2'd1;
              state_q <= S_PSTART;
            end
          end
        end
        S_WRITE: begin
          done_q      <= 1'b1;
          out_index_q <= idx_q;
          for (int c = 0; c < 3; c++) begin
            level_q[c] <= res_row[c].cur;
          end
          active_q  <= res_active;
          changed_q <= res_changed;
          state_q   <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o        = done_q;
  assign out_index_o   = out_index_q;
  assign level_red_o   = level_q[0];
  assign level_green_o = level_q[1];
  assign level_blue_o  = level_q[2];
  assign active_o      = active_q;
  assign changed_o     = changed_q;

endmodule

`default_nettype wire

### hw/rtl/rlfe_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle, shared by all wait computations.
// Depends on rlfe_pkg for the operand widths.

module rlfe_div import rlfe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             run_q;
  logic             done_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        quo_q <= num_i;
        rem_q <= '0;
        den_q <= den_i;
        cnt_q <= CNT_W'(NUM_W - 1);
        run_q <= 1'b1;
      end else if (run_q) begin
        quo_q <= {quo_q[NUM_W-2:0], fits};
        rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CNT_W'(1);
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

### hw/rtl/rlfe_plan.sv
`timescale 1ns / 1ps
`default_nettype none
// Fade planner for one channel: works out the signed step and the wait in ticks.
// Depends on rlfe_pkg and instantiates rlfe_div.

module rlfe_plan import rlfe_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [LEVEL_W-1:0]        from_i,
  input  logic [LEVEL_W-1:0]        to_i,
  input  logic [MORPH_W-1:0]        morph_i,
  input  logic [TICK_W-1:0]         tick_i,
  output logic                      done_o,
  output logic signed [LEVEL_W-1:0] step_o,
  output logic [LEVEL_W-1:0]        wait_o
);

  typedef enum logic [2:0] {
    P_IDLE,
    P_MUL,
    P_DIV1,
    P_DIV2,
    P_MUL2,
    P_DIV3
  } state_e;

  state_e                    state_q;
  logic                      neg_q;
  logic                      div_go_q;
  logic                      done_q;
  logic [LEVEL_W-1:0]        d_q;
  logic [LEVEL_W-1:0]        i_q;
  logic [LEVEL_W-1:0]        wait_q;
  logic signed [LEVEL_W-1:0] step_q;
  logic signed [LEVEL_W-1:0] fb_step_q;
  logic [DD_W-1:0]           dd_q;
  logic [PROD_W-1:0]         prod_q;
  logic                      neg;
  logic [LEVEL_W-1:0]        dmag;
  logic [NUM_W-1:0]          div_num;
  logic [DEN_W-1:0]          div_den;
  logic [NUM_W-1:0]          quot;
  logic                      div_done;

  function automatic logic signed [LEVEL_W-1:0] make_step(logic n, logic [LEVEL_W-1:0] mag);
    logic [LEVEL_W-1:0] m;
    m = (mag > 8'd127) ? 8'd127 : mag;
    return n ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [LEVEL_W-1:0] sat255(logic [NUM_W-1:0] v);
    return (v > NUM_W'(255)) ? 8'd255 : v[LEVEL_W-1:0];
  endfunction

  assign neg  = to_i < from_i;
  assign dmag = neg ? (from_i - to_i) : (to_i - from_i);

  always_comb begin
    case (state_q)
      P_DIV2: begin
        div_num = NUM_W'(dd_q);
        div_den = DEN_W'(morph_i);
      end
      P_DIV3: begin
        div_num = {prod_q, 1'b0} + NUM_W'(dd_q);
        div_den = {dd_q, 1'b0};
      end
      default: begin
        div_num = NUM_W'({morph_i, 1'b0}) + NUM_W'(dd_q);
        div_den = {dd_q, 1'b0};
      end
    endcase
  end

  rlfe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go_q),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= P_IDLE;
      div_go_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q   <= 1'b0;
      div_go_q <= 1'b0;
      unique case (state_q)
        P_IDLE: begin
          if (start_i) begin
            neg_q     <= neg;
            d_q       <= dmag;
            fb_step_q <= make_step(neg, dmag);
            if (dmag == '0) begin
              step_q <= '0;
              wait_q <= '0;
              done_q <= 1'b1;
            end else begin
              state_q <= P_MUL;
            end
          end
        end
        P_MUL: begin
          dd_q     <= DD_W'(d_q) * DD_W'(tick_i);
          div_go_q <= 1'b1;
          state_q  <= P_DIV1;
        end
        P_DIV1: begin
          if (div_done) begin
            if (quot != '0) begin
              step_q  <= make_step(neg_q, 8'd1);
              wait_q  <= sat255(quot);
              done_q  <= 1'b1;
              state_q <= P_IDLE;
            end else if (morph_i == '0) begin
              step_q  <= fb_step_q;
              wait_q  <= 8'd1;
              done_q  <= 1'b1;
              state_q <= P_IDLE;
            end else begin
              div_go_q <= 1'b1;
              state_q  <= P_DIV2;
            end
          end
        end
        P_DIV2: begin
          if (div_done) begin
            if (quot > NUM_W'(253)) begin
              step_q  <= fb_step_q;
              wait_q  <= 8'd1;
              done_q  <= 1'b1;
              state_q <= P_IDLE;
            end else begin
              i_q     <= quot[LEVEL_W-1:0] + 8'd1;
              state_q <= P_MUL2;
            end
          end
        end
        P_MUL2: begin
          prod_q   <= PROD_W'(i_q) * PROD_W'(morph_i);
          div_go_q <= 1'b1;
          state_q  <= P_DIV3;
        end
        P_DIV3: begin
          if (div_done) begin
            step_q  <= make_step(neg_q, i_q);
            wait_q  <= sat255(quot);
            done_q  <= 1'b1;
            state_q <= P_IDLE;
          end
        end
        default: state_q <= P_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign step_o = step_q;
  assign wait_o = wait_q;

endmodule

`default_nettype wire

### hw/rtl/rlfe_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// LED state memory, one row of three channels per LED, registered read port,
// and the clearing pass after reset. Depends on rlfe_pkg for the row layout.

module rlfe_mem import rlfe_pkg::*; #(
  parameter  int unsigned DEPTH = LED_COUNT_DEF,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output row_t          rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  row_t          wr_data_i,
  output logic          ready_o
);

  row_t          mem_q [DEPTH];
  row_t          rd_data_q;
  logic          clearing_q;
  logic [AW-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else if (clearing_q) begin
      if (clr_q == AW'(DEPTH - 1)) begin
        clearing_q <= 1'b0;
      end else begin
        clr_q <= clr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem_q[clr_q] <= '0;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign ready_o   = !clearing_q;

endmodule

`default_nettype wire
